FILE: hw/rtl/fsli_pkg.sv
// Package for the fixed sorted list with insert and binary search.
// Holds the data widths, command codes, sequencer states and cell control struct.
// No dependencies.
`default_nettype none

package fsli_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int INIT_STEP = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_PROBE
    } seq_state_t;

    typedef struct packed {
        logic capture;  // latch comparison flags against the incoming value
        logic apply;    // perform the insert shift using the latched flags
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fsli_cell.sv
// One slot of the sorted list: holds an entry and its comparison flags.
// Depends on fsli_pkg for widths and the cell control struct.
// Hands its entry and the running insert-hit flag to the next cell.
`default_nettype none

module fsli_cell
    import fsli_pkg::*;
#(
    parameter logic signed [DATA_W-1:0] INIT = '0,
    parameter bit                       LAST = 1'b0
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic signed [DATA_W-1:0] wdata,
    input  wire logic signed [DATA_W-1:0] prev_entry,
    input  wire logic                     hit_in,
    output logic signed [DATA_W-1:0]      entry,
    output logic                          hit_out,
    output logic                          lt,
    output logic                          eq
);

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     lt_reg;
    logic                     eq_reg;

    // On an insert, a cell to the right of the insertion point takes its
    // neighbor's entry, the insertion point takes the new value, and the last
    // cell takes the new value when no cell was at least the value.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.apply)
        begin
            if (hit_in)
                entry_next = prev_entry;
            else if (LAST || !lt_reg)
                entry_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= INIT;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            if (ctrl.capture)
            begin
                lt_reg <= (entry_reg < key);
                eq_reg <= (entry_reg == key);
            end
            entry_reg <= entry_next;
        end
    end

    assign entry   = entry_reg;
    assign hit_out = hit_in | ~lt_reg;
    assign lt      = lt_reg;
    assign eq      = eq_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/fsli_seq.sv
// Command sequencer: accepts commands, drives the cells and runs the binary
// search over the comparison flags latched by the cells.
// Depends on fsli_pkg for states, command codes and the cell control struct.
`default_nettype none

module fsli_seq
    import fsli_pkg::*;
#(
    parameter int SLOTS = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic             command,
    input  wire logic [SLOTS-1:0] lt_vec,
    input  wire logic [SLOTS-1:0] eq_vec,
    output logic                  busy,
    output cell_ctrl_t            ctrl,
    output logic                  done,
    output logic                  found,
    output logic [POS_W-1:0]      position
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);

    seq_state_t         state_reg;
    seq_state_t         state_next;
    logic [CNT_W-1:0]   lo_reg;
    logic [CNT_W-1:0]   lo_next;
    logic [CNT_W-1:0]   hp1_reg;    // upper bound plus one
    logic [CNT_W-1:0]   hp1_next;
    logic               done_reg;
    logic               done_next;
    logic               found_reg;
    logic               found_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;

    logic               accept;
    logic               in_range;
    logic [CNT_W:0]     sum;
    logic [CNT_W-1:0]   mid_full;
    logic [IDX_W-1:0]   mid_idx;
    logic               probe_eq;
    logic               probe_lt;
    logic [POS_W+IDX_W-1:0] pos_ext;

    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = (lo_reg < hp1_reg);
    assign sum      = {1'b0, lo_reg} + {1'b0, hp1_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid_full = sum[CNT_W:1];
    assign mid_idx  = mid_full[IDX_W-1:0];
    assign probe_eq = in_range && eq_vec[mid_idx];
    assign probe_lt = in_range && lt_vec[mid_idx];
    assign pos_ext  = {{POS_W{1'b0}}, mid_idx};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (command == CMD_SEARCH) ? ST_PROBE : ST_INSERT;
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            ST_PROBE:
            begin
                if (!in_range || probe_eq)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs toward the cells and the command port.
    always_comb
    begin
        busy         = (state_reg != ST_IDLE);
        ctrl.capture = accept;
        ctrl.apply   = (state_reg == ST_INSERT);
    end

    // Search bounds and result registers.
    always_comb
    begin
        lo_next    = lo_reg;
        hp1_next   = hp1_reg;
        done_next  = 1'b0;
        found_next = 1'b0;
        pos_next   = '0;
        if (accept)
        begin
            lo_next  = '0;
            hp1_next = CNT_W'(SLOTS);
        end
        else if (state_reg == ST_PROBE)
        begin
            if (!in_range)
            begin
                done_next = 1'b1;
            end
            else if (probe_eq)
            begin
                done_next  = 1'b1;
                found_next = 1'b1;
                pos_next   = pos_ext[POS_W-1:0];
            end
            else if (probe_lt)
            begin
                lo_next = mid_full + {{(CNT_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                hp1_next = mid_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lo_reg    <= '0;
            hp1_reg   <= '0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lo_reg    <= lo_next;
            hp1_reg   <= hp1_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            pos_reg   <= pos_next;
        end
    end

    assign done     = done_reg;
    assign found    = found_reg;
    assign position = pos_reg;

    a_done_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_PROBE))
        else $error("result strobe without a preceding search probe");

    a_found_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        found_reg |-> done_reg)
        else $error("found raised outside a result cycle");

    a_bounds_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (lo_reg <= hp1_reg))
        else $error("search bounds crossed by more than one");

    a_apply_single: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.apply |=> !ctrl.apply && !done_reg)
        else $error("insert shift lasted more than one cycle");

endmodule

`default_nettype wire

FILE: hw/rtl/fixed_sorted_list_insert_search.sv
// Top level of the fixed sorted list with insert and binary search.
// Depends on fsli_pkg, fsli_cell and fsli_seq.
//
// The block keeps SLOTS signed 32-bit entries in ascending order, one entry
// per cell in a row of cells; after reset entry k holds 5*(k+1). A command is
// taken when start is high and busy is low. In that same edge every cell
// compares its entry with value and latches "less than" and "equal" flags.
// In an insert (command 0), in the cycle after the command each cell at or
// right of the first entry that is at least the value takes either the
// value or its left neighbor's entry, so the list shifts up by one and the
// old last entry drops out; a value above every entry replaces the last
// entry. An insert gives no item on the result side. A search (command 1)
// walks the binary search over the latched flags, one probe per cycle, and
// busy stays high until the probe loop in the sequencer ends. The result
// item appears for exactly one cycle with done high, in the first cycle in
// which busy is low again, with found and the low four bits of the first
// probed index that matched (position is 0 on a miss). The receiver cannot
// stall the block: a result must be taken in the cycle it is shown, and a
// new command may be given in that same cycle.
`default_nettype none

module fixed_sorted_list_insert_search
    import fsli_pkg::*;
#(
    parameter int SLOTS = 10
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     command,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          done,
    output logic                          found,
    output logic [POS_W-1:0]              position
);

    cell_ctrl_t               ctrl;
    logic signed [DATA_W-1:0] val_reg;
    logic [SLOTS-1:0]         lt_vec;
    logic [SLOTS-1:0]         eq_vec;

    // Neighbor links: entry k and hit flag k feed cell k+1.
    logic signed [DATA_W-1:0] ent_chain [SLOTS+1];
    logic                     hit_chain [SLOTS+1];

    assign ent_chain[0] = '0;
    assign hit_chain[0] = 1'b0;

    // The value is held for the insert shift, done in the following cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
            val_reg <= value;
    end

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        fsli_cell #(
            .INIT (DATA_W'(INIT_STEP * (k + 1))),
            .LAST (k == SLOTS - 1)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (value),
            .wdata      (val_reg),
            .prev_entry (ent_chain[k]),
            .hit_in     (hit_chain[k]),
            .entry      (ent_chain[k+1]),
            .hit_out    (hit_chain[k+1]),
            .lt         (lt_vec[k]),
            .eq         (eq_vec[k])
        );
    end

    fsli_seq #(
        .SLOTS (SLOTS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .command  (command),
        .lt_vec   (lt_vec),
        .eq_vec   (eq_vec),
        .busy     (busy),
        .ctrl     (ctrl),
        .done     (done),
        .found    (found),
        .position (position)
    );

endmodule

`default_nettype wire

FILE: tb/fixed_sorted_list_insert_search_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fixed_sorted_list_insert_search, built on fsli_pkg.
// A shadow copy of the sorted entries predicts every search result; inserts update
// the shadow copy and produce no result. Stimulus is directed first, then random.

module fixed_sorted_list_insert_search_tb;

    import fsli_pkg::*;

    localparam int SLOTS          = 10;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int POOL_DEPTH     = 16;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;

    // One command item as it is handed to the block.
    typedef struct packed {
        logic                     command;
        logic signed [DATA_W-1:0] value;
    } list_cmd_t;

    // One search answer as the block reports it.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } search_answer_t;

    logic                     clk     = 1'b0;
    logic                     rst_n   = 1'b0;
    logic                     start   = 1'b0;
    logic                     command = CMD_INSERT;
    logic signed [DATA_W-1:0] value   = '0;
    logic                     busy;
    logic                     done;
    logic                     found;
    logic [POS_W-1:0]         position;

    // Commands still waiting to be driven, and search answers still waiting to come back.
    list_cmd_t                pending_cmds[$];
    search_answer_t           search_answers[$];

    // Shadow copy of the sorted entries; it is kept in step with every accepted item.
    logic signed [DATA_W-1:0] shadow_entries[SLOTS];

    // Recently used keys, so that random searches and duplicate inserts often hit.
    logic signed [DATA_W-1:0] key_pool[POOL_DEPTH];
    int                       pool_wr = 0;

    int                       mismatches  = 0;
    int                       idle_left   = 0;
    int                       burst_left  = 0;
    int                       quiet_count = 0;

    fixed_sorted_list_insert_search #(
        .SLOTS    (SLOTS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .command  (command),
        .value    (value),
        .done     (done),
        .found    (found),
        .position (position)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one accepted item to the shadow entries. An insert finds the first entry
    // that is at least the key, shifts the later entries up one slot and drops the
    // old last entry; a key above every entry simply replaces the last entry, which
    // the same shift loop covers since the slot then defaults to the last one.
    // A search walks the binary probe order and queues the answer the block must give.
    function automatic void apply_list_command(input list_cmd_t item);
        int             slot;
        int             lo;
        int             hi;
        int             mid;
        search_answer_t answer;
        if (item.command == CMD_INSERT)
        begin
            slot = SLOTS - 1;
            for (int k = SLOTS - 1; k >= 0; k--)
            begin
                if (shadow_entries[k] >= item.value)
                    slot = k;
            end
            for (int k = SLOTS - 1; k > slot; k--)
                shadow_entries[k] = shadow_entries[k - 1];
            shadow_entries[slot] = item.value;
        end
        else
        begin
            lo     = 0;
            hi     = SLOTS - 1;
            answer = '0;
            while (lo <= hi && !answer.found)
            begin
                mid = (lo + hi) / 2;
                if (shadow_entries[mid] == item.value)
                begin
                    answer.found    = 1'b1;
                    answer.position = mid[POS_W-1:0];
                end
                else if (shadow_entries[mid] < item.value)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            search_answers.push_back(answer);
        end
    endfunction

    task automatic queue_cmd(input logic cmd, input logic signed [DATA_W-1:0] key);
        list_cmd_t item;
        item.command = cmd;
        item.value   = key;
        pending_cmds.push_back(item);
        if (cmd == CMD_INSERT)
        begin
            key_pool[pool_wr] = key;
            pool_wr           = (pool_wr + 1) % POOL_DEPTH;
        end
    endtask

    // Driver. An item is taken at an edge where start is high and busy is low; start
    // then either moves straight on to the next item or drops for a random gap.
    // While start is low the command and value lines carry noise that must be ignored.
    always @(posedge clk)
    begin
        list_cmd_t item;
        logic      taken;
        if (rst_n)
        begin
            taken = start && !busy;
            if (taken)
            begin
                item.command = command;
                item.value   = value;
                apply_list_command(item);
            end
            if (!start || taken)
            begin
                if (idle_left > 0 || pending_cmds.size() == 0)
                begin
                    if (idle_left > 0)
                        idle_left--;
                    start   <= 1'b0;
                    command <= logic'($urandom_range(1));
                    value   <= $urandom;
                end
                else
                begin
                    item     = pending_cmds.pop_front();
                    start   <= 1'b1;
                    command <= item.command;
                    value   <= item.value;
                    // Most gaps are short, a few are long, and now and then a burst
                    // of back-to-back items runs with no gap at all.
                    if (burst_left > 0)
                    begin
                        burst_left--;
                        idle_left = 0;
                    end
                    else
                    begin
                        case ($urandom_range(99)) inside
                            [0:2]:   begin
                                         burst_left = $urandom_range(60, 20);
                                         idle_left  = 0;
                                     end
                            [3:54]:  idle_left = 0;
                            [55:89]: idle_left = $urandom_range(3, 1);
                            default: idle_left = $urandom_range(30, 4);
                        endcase
                    end
                end
            end
        end
    end

    // Monitor. A result is on the ports for exactly one cycle with done high, and it
    // is compared with the oldest search answer still owed.
    always @(posedge clk)
    begin
        search_answer_t want;
        if (rst_n && done)
        begin
            if (search_answers.size() == 0)
            begin
                $display("%0t: result with none owed, expected nothing, actual found=%0b position=%0d",
                         $time, found, position);
                mismatches++;
            end
            else
            begin
                want = search_answers.pop_front();
                if (found !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, found);
                    mismatches++;
                end
                if (position !== want.position)
                begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.position, position);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. It counts cycles in which no item is taken and no result is shown.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d items pending and %0d answers owed",
                         $time, pending_cmds.size(), search_answers.size());
                $display("fixed_sorted_list_insert_search_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic                     cmd;
        logic signed [DATA_W-1:0] key;
        int                       pick;

        // After reset entry k holds 5 times (k+1); the key pool starts with the same keys.
        for (int k = 0; k < SLOTS; k++)
            shadow_entries[k] = DATA_W'(5 * (k + 1));
        for (int k = 0; k < POOL_DEPTH; k++)
            key_pool[k] = DATA_W'(5 * ((k % SLOTS) + 1));

        // Directed part: hits at both ends and in the middle of the reset list, misses
        // between entries and at the extremes, a key above every entry, a key equal to
        // the largest entry, a key below every entry, and duplicate entries.
        queue_cmd(CMD_SEARCH, 5);
        queue_cmd(CMD_SEARCH, 50);
        queue_cmd(CMD_SEARCH, 25);
        queue_cmd(CMD_SEARCH, 30);
        queue_cmd(CMD_SEARCH, 7);
        queue_cmd(CMD_SEARCH, MOST_NEGATIVE);
        queue_cmd(CMD_SEARCH, MOST_POSITIVE);
        queue_cmd(CMD_INSERT, MOST_POSITIVE);
        queue_cmd(CMD_SEARCH, MOST_POSITIVE);
        queue_cmd(CMD_SEARCH, 50);
        queue_cmd(CMD_INSERT, MOST_POSITIVE);
        queue_cmd(CMD_SEARCH, 45);
        queue_cmd(CMD_INSERT, MOST_NEGATIVE);
        queue_cmd(CMD_SEARCH, MOST_NEGATIVE);
        queue_cmd(CMD_INSERT, 20);
        queue_cmd(CMD_INSERT, 20);
        queue_cmd(CMD_SEARCH, 20);
        queue_cmd(CMD_SEARCH, 45);
        queue_cmd(CMD_INSERT, 0);
        queue_cmd(CMD_SEARCH, 0);
        queue_cmd(CMD_INSERT, -1);
        queue_cmd(CMD_SEARCH, -1);
        queue_cmd(CMD_INSERT, 12);
        queue_cmd(CMD_SEARCH, 35);

        // Random part. Keys mostly come from the pool of recent keys or lie close to
        // them, so that searches hit and inserts land among existing entries and make
        // duplicates; the rest are small keys from -100 to 100, the extremes, -1 and 0, and full-width random keys.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            cmd  = ($urandom_range(99) < 45) ? CMD_INSERT : CMD_SEARCH;
            key  = key_pool[$urandom_range(POOL_DEPTH - 1)];
            pick = $urandom_range(99);
            if (pick < 40)
                key = int'(key) + int'($urandom_range(6)) - 3;
            else if (pick < 55)
                key = key;
            else if (pick < 70)
                key = int'($urandom_range(200)) - 100;
            else if (pick < 80)
            begin
                case ($urandom_range(3))
                    0:       key = MOST_NEGATIVE;
                    1:       key = MOST_POSITIVE;
                    2:       key = -1;
                    default: key = 0;
                endcase
            end
            else
                key = $urandom;
            queue_cmd(cmd, key);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every item has been taken and every answer has come back, then
        // let the drain wait run so that any stray result is still seen.
        while (pending_cmds.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (start || search_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("fixed_sorted_list_insert_search_tb: PASS");
        else
            $display("fixed_sorted_list_insert_search_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/fsli_pkg.sv
hw/rtl/fsli_cell.sv
hw/rtl/fsli_seq.sv
hw/rtl/fixed_sorted_list_insert_search.sv
tb/fixed_sorted_list_insert_search_tb.sv
